>>> hdl/swrs_pkg.sv
// Shared definitions for the sample stack with running statistics.
// Holds result field widths, fixed-point formats, action codes and control structs.
// Depends on nothing.
`timescale 1ns / 1ps
package swrs_pkg;
  localparam int POPPED_W = 16;
  localparam int TOP_W    = 16;
  localparam int COUNT_W  = 7;
  localparam int TOTAL_W  = 22;
  localparam int LARGE_W  = 16;
  localparam int SMALL_W  = 16;
  localparam int MEAN_W   = 26;
  localparam int VAR_W    = 39;

  localparam int MEAN_FRAC = 10;
  localparam int VAR_FRAC  = 8;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

>>> hdl/swrs_front.sv
// Front queue: accepts push/pop items and holds them for the back end.
// Two-entry FIFO of action and sample. Depends on nothing.
`timescale 1ns / 1ps
module swrs_front #(
  parameter int SW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_push,
  input  logic          in_action,
  input  logic [SW-1:0] in_value,
  output logic          in_full,
  output logic          item_valid,
  output logic          item_action,
  output logic [SW-1:0] item_value,
  input  logic          item_take
);
  logic          act_q [2];
  logic [SW-1:0] val_q [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    fill;
  logic          wr_en;
  logic          rd_en;

  assign in_full     = (fill == 2'd2);
  assign item_valid  = (fill != 2'd0);
  assign item_action = act_q[rptr];
  assign item_value  = val_q[rptr];
  assign wr_en       = in_push && !in_full;
  assign rd_en       = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      act_q[wptr] <= in_action;
      val_q[wptr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) wptr <= ~wptr;
      if (rd_en) rptr <= ~rptr;
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end
endmodule

>>> hdl/swrs_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses the control structs of swrs_pkg.
`timescale 1ns / 1ps
module swrs_div #(
  parameter int N_W = 56,
  parameter int D_W = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  swrs_pkg::div_ctrl_t ctrl,
  input  logic [N_W-1:0]      dividend,
  input  logic [D_W-1:0]      divisor,
  output swrs_pkg::div_stat_t stat,
  output logic [N_W-1:0]      quotient
);
  import swrs_pkg::*;

  localparam int CW = $clog2(N_W + 1);

  logic [N_W-1:0] quo;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [CW-1:0]  cnt;
  logic           busy;
  logic           done;
  logic [D_W:0]   trial;
  logic           qbit;
  logic [D_W-1:0] rem_next;

  assign trial    = {rem, quo[N_W-1]};
  assign qbit     = (trial >= {1'b0, dvs});
  assign rem_next = qbit ? D_W'(trial - {1'b0, dvs}) : trial[D_W-1:0];
  assign quotient = quo;
  assign stat     = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (ctrl.start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(N_W - 1));
      if (ctrl.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (cnt == CW'(N_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end
endmodule

>>> hdl/swrs_back.sv
// Back end: stack stores, running sums, statistics sequencer and result register.
// Depends on swrs_pkg and swrs_div.
`timescale 1ns / 1ps
module swrs_back #(
  parameter int STACK_DEPTH = 64,
  parameter int SW          = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_action,
  input  logic signed [SW-1:0]              item_value,
  output logic                              item_take,
  output logic                              res_valid,
  input  logic                              res_pop,
  output logic signed [swrs_pkg::POPPED_W-1:0] popped_value,
  output logic signed [swrs_pkg::TOP_W-1:0]    top_value,
  output logic [swrs_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [swrs_pkg::TOTAL_W-1:0]  total,
  output logic signed [swrs_pkg::LARGE_W-1:0]  largest,
  output logic signed [swrs_pkg::SMALL_W-1:0]  smallest,
  output logic signed [swrs_pkg::MEAN_W-1:0]   mean_fixed,
  output logic [swrs_pkg::VAR_W-1:0]           variance_fixed,
  output logic                              error
);
  import swrs_pkg::*;

  localparam int AW     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SUM_W  = SW + CNT_W;
  localparam int SQ_W   = 2 * SW + CNT_W;
  localparam int NSQ_W  = SQ_W + CNT_W;
  localparam int SMSQ_W = 2 * SUM_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int DVS_W  = DEN_W + 1;
  localparam int DA_W   = NSQ_W + VAR_FRAC + 2;
  localparam int DB_W   = SUM_W + MEAN_FRAC + 2;
  localparam int DIV_W  = (DA_W > DB_W) ? DA_W : DB_W;

  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX = ~SMIN;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD1   = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_VAR   = 4'd6;
  localparam logic [3:0] S_VWAIT = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]              state;
  logic [CNT_W-1:0]        n;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;

  logic signed [SW-1:0] entry_store [STACK_DEPTH];
  logic signed [SW-1:0] max_store   [STACK_DEPTH];
  logic signed [SW-1:0] min_store   [STACK_DEPTH];
  logic signed [SW-1:0] rd_e;
  logic signed [SW-1:0] rd_max;
  logic signed [SW-1:0] rd_min;
  logic [AW-1:0]        raddr;
  logic                 we;

  logic                 act;
  logic signed [SW-1:0] val;
  logic                 err;
  logic signed [SW-1:0] popped;
  logic signed [SW-1:0] top;
  logic signed [SW-1:0] big;
  logic signed [SW-1:0] least;
  logic [SUM_W-1:0]     sm;
  logic                 neg;
  logic [NSQ_W-1:0]     nsq;
  logic [SMSQ_W-1:0]    smsq;
  logic [DEN_W-1:0]     den;
  logic [DIV_W-1:0]     mean_q;
  logic [DIV_W-1:0]     var_q;

  logic signed [SW-1:0]   pmax;
  logic signed [SW-1:0]   pmin;
  logic signed [SW-1:0]   vmax;
  logic signed [SW-1:0]   vmin;
  logic signed [2*SW-1:0] val_sq;
  logic signed [2*SW-1:0] rd_sq;
  logic [SUM_W-1:0]       sum_abs;
  logic [SMSQ_W-1:0]      sum_abs_sq;
  logic [NSQ_W-1:0]       n_times_sq;
  logic [DEN_W-1:0]       n_sq;

  div_ctrl_t        dctrl;
  div_stat_t        dstat;
  logic [DIV_W-1:0] dividend;
  logic [DVS_W-1:0] divisor;
  logic [DIV_W-1:0] quotient;

  assign item_take  = (state == S_IDLE) && item_valid;
  assign raddr      = (state == S_RD1) ? AW'(n - CNT_W'(2)) : AW'(n - CNT_W'(1));
  assign we         = (state == S_RD1) && !err && (act == ACT_PUSH);
  assign pmax       = (n == '0) ? SMIN : rd_max;
  assign pmin       = (n == '0) ? SMAX : rd_min;
  assign vmax       = (val > pmax) ? val : pmax;
  assign vmin       = (val < pmin) ? val : pmin;
  assign val_sq     = val * val;
  assign rd_sq      = rd_e * rd_e;
  assign sum_abs    = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign sum_abs_sq = sum_abs * sum_abs;
  assign n_times_sq = NSQ_W'(n) * NSQ_W'(sq);
  assign n_sq       = DEN_W'(n) * DEN_W'(n);

  assign dctrl.start = (state == S_MEAN) || (state == S_VAR);
  always_comb begin
    if (state == S_VAR) begin
      dividend = (DIV_W'(nsq - NSQ_W'(smsq)) << (VAR_FRAC + 1)) + DIV_W'(den);
      divisor  = {den, 1'b0};
    end else begin
      dividend = (DIV_W'(sm) << (MEAN_FRAC + 1)) + DIV_W'(n);
      divisor  = DVS_W'({n, 1'b0});
    end
  end

  swrs_div #(.N_W(DIV_W), .D_W(DVS_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (dctrl),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (dstat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      entry_store[AW'(n)] <= val;
      max_store[AW'(n)]   <= vmax;
      min_store[AW'(n)]   <= vmin;
    end
    rd_e   <= entry_store[raddr];
    rd_max <= max_store[raddr];
    rd_min <= min_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      sum       <= '0;
      sq        <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_pop) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            act   <= item_action;
            val   <= item_value;
            err   <= (item_action == ACT_POP) ? (n == '0) : (n == CNT_W'(STACK_DEPTH));
            state <= S_RD1;
          end
        end
        S_RD1: begin
          if (err) begin
            popped <= '0;
            top    <= (n == '0) ? '0 : rd_e;
            big    <= (n == '0) ? SMIN : rd_max;
            least  <= (n == '0) ? SMAX : rd_min;
            state  <= S_MUL;
          end else if (act == ACT_PUSH) begin
            popped <= '0;
            top    <= val;
            big    <= vmax;
            least  <= vmin;
            sum    <= sum + SUM_W'(val);
            sq     <= sq + SQ_W'(unsigned'(val_sq));
            n      <= n + CNT_W'(1);
            state  <= S_MUL;
          end else begin
            popped <= rd_e;
            sum    <= sum - SUM_W'(rd_e);
            sq     <= sq - SQ_W'(unsigned'(rd_sq));
            n      <= n - CNT_W'(1);
            state  <= S_RD2;
          end
        end
        S_RD2: begin
          top   <= (n == '0) ? '0 : rd_e;
          big   <= (n == '0) ? SMIN : rd_max;
          least <= (n == '0) ? SMAX : rd_min;
          state <= S_MUL;
        end
        S_MUL: begin
          sm   <= sum_abs;
          neg  <= sum[SUM_W-1];
          nsq  <= n_times_sq;
          smsq <= sum_abs_sq;
          den  <= n_sq;
          if (n == '0) begin
            mean_q <= '0;
            var_q  <= '0;
            state  <= S_OUT;
          end else begin
            state <= S_MEAN;
          end
        end
        S_MEAN: state <= S_MWAIT;
        S_MWAIT: begin
          if (dstat.done) begin
            mean_q <= quotient;
            state  <= S_VAR;
          end
        end
        S_VAR: state <= S_VWAIT;
        S_VWAIT: begin
          if (dstat.done) begin
            var_q <= quotient;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid) begin
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && !res_valid) begin
      popped_value   <= POPPED_W'(popped);
      top_value      <= TOP_W'(top);
      entry_count    <= COUNT_W'(n);
      total          <= TOTAL_W'(sum);
      largest        <= LARGE_W'(big);
      smallest       <= SMALL_W'(least);
      mean_fixed     <= neg ? MEAN_W'(-mean_q) : MEAN_W'(mean_q);
      variance_fixed <= VAR_W'(var_q);
      error          <= err;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(STACK_DEPTH))
    else $error("entry count above stack depth");

  a_err_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD1 && err) |=> ($stable(n) && $stable(sum) && $stable(sq)))
    else $error("rejected item changed the stack");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == S_MWAIT || state == S_VWAIT))
    else $error("divider finished outside a wait state");
endmodule

>>> hdl/stack_with_running_statistics.sv
// Bounded stack of signed samples with running count, sum, max, min, mean, variance.
// Input channel: push/full carries action (0 push, 1 pop) and value. Result channel:
// empty/pop carries popped_value, top_value, entry_count, total, largest, smallest,
// mean_fixed (10 fraction bits), variance_fixed (8 fraction bits) and error.
// A two-entry input queue decouples the sender from the statistics engine, and a
// result register holds one finished result while the next item is worked on.
// The engine takes the next item only after finishing the current one. The shared
// one-bit-per-cycle divider, 56 bits wide for the default sizing, computes the mean
// and then the variance; items that leave the stack empty skip the divider.
// Reset empties the stack, the input queue and the result register. While the result
// receiver stalls, the engine finishes the current item and waits; the input queue
// keeps taking items until it is full.
// Depends on swrs_pkg, swrs_front, swrs_back.
`timescale 1ns / 1ps
module stack_with_running_statistics #(
  parameter int STACK_DEPTH  = 64,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  output logic                                 full,
  input  logic                                 action,
  input  logic signed [SAMPLE_WIDTH-1:0]       value,
  output logic                                 empty,
  input  logic                                 pop,
  output logic signed [swrs_pkg::POPPED_W-1:0] popped_value,
  output logic signed [swrs_pkg::TOP_W-1:0]    top_value,
  output logic [swrs_pkg::COUNT_W-1:0]         entry_count,
  output logic signed [swrs_pkg::TOTAL_W-1:0]  total,
  output logic signed [swrs_pkg::LARGE_W-1:0]  largest,
  output logic signed [swrs_pkg::SMALL_W-1:0]  smallest,
  output logic signed [swrs_pkg::MEAN_W-1:0]   mean_fixed,
  output logic [swrs_pkg::VAR_W-1:0]           variance_fixed,
  output logic                                 error
);
  import swrs_pkg::*;

  logic                    item_valid;
  logic                    item_action;
  logic [SAMPLE_WIDTH-1:0] item_value;
  logic                    item_take;
  logic                    res_valid;

  assign empty = !res_valid;

  swrs_front #(.SW(SAMPLE_WIDTH)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_push     (push),
    .in_action   (action),
    .in_value    (value),
    .in_full     (full),
    .item_valid  (item_valid),
    .item_action (item_action),
    .item_value  (item_value),
    .item_take   (item_take)
  );

  swrs_back #(.STACK_DEPTH(STACK_DEPTH), .SW(SAMPLE_WIDTH)) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_action    (item_action),
    .item_value     (signed'(item_value)),
    .item_take      (item_take),
    .res_valid      (res_valid),
    .res_pop        (pop),
    .popped_value   (popped_value),
    .top_value      (top_value),
    .entry_count    (entry_count),
    .total          (total),
    .largest        (largest),
    .smallest       (smallest),
    .mean_fixed     (mean_fixed),
    .variance_fixed (variance_fixed),
    .error          (error)
  );
endmodule

>>> dv/swrs_checker.sv
// Checker for the sample stack with running statistics: watches both queue channels,
// predicts every result from its own copy of the stack and compares field by field.
// Depends on swrs_pkg.
`timescale 1ns / 1ps
module swrs_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  logic                                 full,
  input  logic                                 action,
  input  logic signed [15:0]                   value,
  input  logic                                 empty,
  input  logic                                 pop,
  input  logic signed [swrs_pkg::POPPED_W-1:0] popped_value,
  input  logic signed [swrs_pkg::TOP_W-1:0]    top_value,
  input  logic [swrs_pkg::COUNT_W-1:0]         entry_count,
  input  logic signed [swrs_pkg::TOTAL_W-1:0]  total,
  input  logic signed [swrs_pkg::LARGE_W-1:0]  largest,
  input  logic signed [swrs_pkg::SMALL_W-1:0]  smallest,
  input  logic signed [swrs_pkg::MEAN_W-1:0]   mean_fixed,
  input  logic [swrs_pkg::VAR_W-1:0]           variance_fixed,
  input  logic                                 error,
  output int                                   fail_count,
  output int                                   pending
);
  import swrs_pkg::*;

  localparam int DEPTH = 64;
  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh8000;

  typedef struct {
    logic signed [POPPED_W-1:0] popped;
    logic signed [TOP_W-1:0]    top;
    logic [COUNT_W-1:0]         count;
    logic signed [TOTAL_W-1:0]  sum;
    logic signed [LARGE_W-1:0]  big;
    logic signed [SMALL_W-1:0]  little;
    logic signed [MEAN_W-1:0]   mean;
    logic [VAR_W-1:0]           var_fx;
    logic                       err;
  } stats_t;

  logic signed [15:0] stack_mem [DEPTH];
  logic signed [15:0] max_mem [DEPTH];
  logic signed [15:0] min_mem [DEPTH];
  int                 depth;
  longint             sum_acc;
  longint unsigned    sq_acc;
  stats_t             expected_stats [$];

  function automatic stats_t predict_stats(logic act, logic signed [15:0] v);
    stats_t          r;
    longint          popped;
    longint unsigned mag;
    longint unsigned n;
    longint unsigned sm;
    longint unsigned q;
    longint unsigned num;
    longint unsigned den;
    logic signed [15:0] pmax;
    logic signed [15:0] pmin;
    popped = 0;
    r.err = 1'b0;
    if (act == ACT_POP) begin
      if (depth == 0) begin
        r.err = 1'b1;
      end else begin
        popped = stack_mem[depth-1];
        mag = popped < 0 ? -popped : popped;
        sum_acc -= popped;
        sq_acc -= mag * mag;
        depth--;
      end
    end else begin
      if (depth >= DEPTH) begin
        r.err = 1'b1;
      end else begin
        pmax = depth ? max_mem[depth-1] : SAMPLE_MIN;
        pmin = depth ? min_mem[depth-1] : SAMPLE_MAX;
        stack_mem[depth] = v;
        max_mem[depth] = v > pmax ? v : pmax;
        min_mem[depth] = v < pmin ? v : pmin;
        mag = v < 0 ? -longint'(v) : longint'(v);
        sum_acc += v;
        sq_acc += mag * mag;
        depth++;
      end
    end
    r.popped = POPPED_W'(popped);
    r.count = COUNT_W'(depth);
    r.sum = TOTAL_W'(sum_acc);
    if (depth == 0) begin
      r.top = '0;
      r.big = SAMPLE_MIN;
      r.little = SAMPLE_MAX;
      r.mean = '0;
      r.var_fx = '0;
    end else begin
      n = depth;
      sm = sum_acc < 0 ? -sum_acc : sum_acc;
      r.top = stack_mem[depth-1];
      r.big = max_mem[depth-1];
      r.little = min_mem[depth-1];
      q = ((sm << (MEAN_FRAC + 1)) + n) / (2 * n);
      r.mean = MEAN_W'(sum_acc < 0 ? -longint'(q) : longint'(q));
      num = n * sq_acc - sm * sm;
      den = n * n;
      r.var_fx = VAR_W'(((num << (VAR_FRAC + 1)) + den) / (2 * den));
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    stats_t e;
    if (rst) begin
      depth = 0;
      sum_acc = 0;
      sq_acc = 0;
      fail_count = 0;
      expected_stats.delete();
    end else begin
      if (push && !full) expected_stats.push_back(predict_stats(action, value));
      if (pop && !empty) begin
        if (expected_stats.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          e = expected_stats.pop_front();
          if (popped_value !== e.popped) report_mismatch("popped_value", popped_value, e.popped);
          if (top_value !== e.top) report_mismatch("top_value", top_value, e.top);
          if (entry_count !== e.count) report_mismatch("entry_count", entry_count, e.count);
          if (total !== e.sum) report_mismatch("total", total, e.sum);
          if (largest !== e.big) report_mismatch("largest", largest, e.big);
          if (smallest !== e.little) report_mismatch("smallest", smallest, e.little);
          if (mean_fixed !== e.mean) report_mismatch("mean_fixed", mean_fixed, e.mean);
          if (variance_fixed !== e.var_fx)
            report_mismatch("variance_fixed", variance_fixed, e.var_fx);
          if (error !== e.err) report_mismatch("error", error, e.err);
        end
      end
    end
    pending = expected_stats.size();
  end
endmodule

>>> dv/tb_stack_with_running_statistics.sv
// Top of the stack statistics testbench: clock, reset, push/pop stimulus with random
// gaps and stalls, and the verdict. Depends on swrs_pkg, swrs_checker and the block.
`timescale 1ns / 1ps
module tb_stack_with_running_statistics;
  import swrs_pkg::*;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic                        action = ACT_PUSH;
  logic signed [15:0]          value = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic signed [POPPED_W-1:0]  popped_value;
  logic signed [TOP_W-1:0]     top_value;
  logic [COUNT_W-1:0]          entry_count;
  logic signed [TOTAL_W-1:0]   total;
  logic signed [LARGE_W-1:0]   largest;
  logic signed [SMALL_W-1:0]   smallest;
  logic signed [MEAN_W-1:0]    mean_fixed;
  logic [VAR_W-1:0]            variance_fixed;
  logic                        error;
  int                          fail_count;
  int                          pending;
  int                          received = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  stack_with_running_statistics i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .value(value),
    .empty(empty), .pop(pop), .popped_value(popped_value), .top_value(top_value),
    .entry_count(entry_count), .total(total), .largest(largest), .smallest(smallest),
    .mean_fixed(mean_fixed), .variance_fixed(variance_fixed), .error(error)
  );

  swrs_checker i_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .action(action), .value(value),
    .empty(empty), .pop(pop), .popped_value(popped_value), .top_value(top_value),
    .entry_count(entry_count), .total(total), .largest(largest), .smallest(smallest),
    .mean_fixed(mean_fixed), .variance_fixed(variance_fixed), .error(error),
    .fail_count(fail_count), .pending(pending)
  );

  task automatic send_item(logic act, logic signed [15:0] v);
    int gap;
    gap = $urandom_range(0, 12);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    action <= act;
    value <= v;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic logic signed [15:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return -16'sh8000;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: random stalls, one long hold-off so the input side fills
  initial begin
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (received == 250) gap = 2000;
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      received++;
    end
  end

  initial begin
    int burst;
    int push_pct;
    int items;
    bit paused;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(ACT_POP, 16'sh1234);
    send_item(ACT_PUSH, 16'sh7fff);
    send_item(ACT_PUSH, -16'sh8000);
    send_item(ACT_PUSH, 16'sh0000);
    send_item(ACT_PUSH, -16'sh0001);
    send_item(ACT_PUSH, 16'sh0001);
    repeat (5) send_item(ACT_POP, 16'shffff);
    send_item(ACT_POP, 16'sh0000);
    send_item(ACT_PUSH, -16'sh8000);
    send_item(ACT_PUSH, -16'sh8000);
    send_item(ACT_POP, 16'sh5555);
    send_item(ACT_POP, -16'sh5556);
    send_item(ACT_PUSH, 16'sh7fff);
    send_item(ACT_PUSH, 16'sh7fff);
    send_item(ACT_POP, 16'sh0000);
    send_item(ACT_POP, 16'sh0000);

    // fill past full, then drain past empty
    repeat (70) send_item(ACT_PUSH, draw_sample());
    repeat (70) send_item(ACT_POP, 16'($urandom));

    items = 160;
    while (items < 850) begin
      burst = $urandom_range(20, 80);
      if (burst > 850 - items) burst = 850 - items;
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (burst) begin
        send_item($urandom_range(1, 100) <= push_pct ? ACT_PUSH : ACT_POP, draw_sample());
        items++;
      end
      if (items > 450 && !paused) begin
        paused = 1'b1;
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("status: fail");
    $finish;
  end
endmodule

>>> stack_with_running_statistics.f
hdl/swrs_pkg.sv
hdl/swrs_front.sv
hdl/swrs_div.sv
hdl/swrs_back.sv
hdl/stack_with_running_statistics.sv
dv/swrs_checker.sv
dv/tb_stack_with_running_statistics.sv
